FILE: hdl/length_prefixed_string_frame_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed string frame parser
// Shared wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_STRING_FRAME_PARSER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_STRING_FRAME_PARSER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPSFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lpsfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Types, codes and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
package lpsfp_pkg;

  localparam int QUERY_SIZE = 1024;
  localparam int LEN_W      = $clog2(QUERY_SIZE);
  localparam int PROD_W     = LEN_W + 4;
  localparam int IDX_W      = 10;
  localparam int BC_W       = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_D0 = 8'd48;
  localparam logic [7:0] CH_D9 = 8'd57;

  localparam logic [7:0] MARKER_OK_RST  = 8'd36;
  localparam logic [7:0] MARKER_ERR_RST = 8'd45;

  localparam logic [CFG_IDX_W-1:0] REG_MARKER_OK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_ERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ERR = 2'd2;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_MARKER   = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG = 3'd2;
  localparam logic [2:0] ERR_OVERRUN  = 3'd3;
  localparam logic [2:0] ERR_MISMATCH = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic [IDX_W-1:0] declared_length;
    logic [BC_W-1:0] frame_bytes;
    logic            error_string;
    logic [2:0]      error_code;
  } res_t;

  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic res_t mk_err(input logic [2:0] code, input logic es);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.error_string = es;
    return r;
  endfunction

  function automatic res_t mk_pay(input logic [7:0] b, input logic [LEN_W-1:0] idx);
    res_t r;
    r = '0;
    r.kind = KIND_PAYLOAD;
    r.payload_byte = b;
    r.byte_index = IDX_W'(idx);
    return r;
  endfunction

  function automatic res_t mk_done(input logic [LEN_W-1:0] len, input logic [BC_W-1:0] fb,
                                   input logic es);
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.declared_length = IDX_W'(len);
    r.frame_bytes = fb;
    r.error_string = es;
    return r;
  endfunction

endpackage

FILE: hdl/lpsfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front end
// Holds the configuration and the parse state, and turns each byte into at
// most one queue entry of one or two results.
// ----------------------------------------------------------------------------
module lpsfp_front import lpsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output logic                 push,
  output entry_t               entry
);

  logic [7:0]       marker_ok;
  logic [7:0]       marker_err;
  logic             accept_err;
  phase_t           phase, phase_next;
  logic             cr_pending, cr_pending_next;
  logic [LEN_W-1:0] length_value, length_value_next;
  logic             length_too_big, length_too_big_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic [BC_W-1:0]  byte_count, byte_count_next;
  logic             is_error_frame, is_error_frame_next;

  logic              emit0, emit1;
  res_t              r0, r1;
  logic [BC_W-1:0]   bc_inc;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  pc_inc;
  logic              is_digit, open_ok, open_err;

  always_comb begin
    phase_next          = phase;
    cr_pending_next     = cr_pending;
    length_value_next   = length_value;
    length_too_big_next = length_too_big;
    payload_count_next  = payload_count;
    byte_count_next     = byte_count;
    is_error_frame_next = is_error_frame;
    emit0 = 1'b0;
    emit1 = 1'b0;
    r0 = '0;
    r1 = '0;
    bc_inc = (byte_count != {BC_W{1'b1}}) ? byte_count + 1'b1 : byte_count;
    prod = PROD_W'(length_value) * PROD_W'(10) + PROD_W'(byte_in[3:0]);
    pc_inc = payload_count + 1'b1;
    is_digit = (byte_in >= CH_D0) && (byte_in <= CH_D9);
    open_ok = (byte_in == marker_ok);
    open_err = !open_ok && accept_err && (byte_in == marker_err);
    case (phase)
      PH_LEN: begin
        byte_count_next = bc_inc;
        if (cr_pending) begin
          cr_pending_next = 1'b0;
          if (byte_in == CH_LF) begin
            if (length_too_big) begin
              emit0 = 1'b1;
              r0 = mk_err(ERR_TOO_LONG, is_error_frame);
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_PAY;
              payload_count_next = '0;
            end
          end else begin
            emit0 = 1'b1;
            r0 = mk_err(ERR_DIGIT, is_error_frame);
            phase_next = PH_IDLE;
          end
        end else if (byte_in == CH_CR) begin
          cr_pending_next = 1'b1;
        end else if (is_digit) begin
          if (!length_too_big) begin
            length_value_next = LEN_W'(prod);
            if (prod >= PROD_W'(QUERY_SIZE)) begin
              length_too_big_next = 1'b1;
            end
          end
        end else begin
          emit0 = 1'b1;
          r0 = mk_err(ERR_DIGIT, is_error_frame);
          phase_next = PH_IDLE;
        end
      end
      PH_PAY: begin
        byte_count_next = bc_inc;
        if (cr_pending) begin
          if (byte_in == CH_LF) begin
            emit0 = 1'b1;
            phase_next = PH_IDLE;
            cr_pending_next = 1'b0;
            if (payload_count == length_value) begin
              r0 = mk_done(length_value, bc_inc, is_error_frame);
            end else begin
              r0 = mk_err(ERR_MISMATCH, is_error_frame);
            end
          end else if (payload_count >= length_value) begin
            emit0 = 1'b1;
            r0 = mk_err(ERR_OVERRUN, is_error_frame);
            phase_next = PH_IDLE;
            cr_pending_next = 1'b0;
          end else begin
            emit0 = 1'b1;
            r0 = mk_pay(CH_CR, payload_count);
            payload_count_next = pc_inc;
            if (byte_in != CH_CR) begin
              cr_pending_next = 1'b0;
              emit1 = 1'b1;
              if (pc_inc >= length_value) begin
                r1 = mk_err(ERR_OVERRUN, is_error_frame);
                phase_next = PH_IDLE;
              end else begin
                r1 = mk_pay(byte_in, pc_inc);
                payload_count_next = pc_inc + 1'b1;
              end
            end
          end
        end else if (byte_in == CH_CR) begin
          cr_pending_next = 1'b1;
        end else begin
          emit0 = 1'b1;
          if (payload_count >= length_value) begin
            r0 = mk_err(ERR_OVERRUN, is_error_frame);
            phase_next = PH_IDLE;
          end else begin
            r0 = mk_pay(byte_in, payload_count);
            payload_count_next = pc_inc;
          end
        end
      end
      default: begin
        if (open_ok || open_err) begin
          phase_next = PH_LEN;
          is_error_frame_next = open_err;
          byte_count_next = BC_W'(1);
          length_value_next = '0;
          length_too_big_next = 1'b0;
          payload_count_next = '0;
          cr_pending_next = 1'b0;
        end else begin
          emit0 = 1'b1;
          r0 = mk_err(ERR_MARKER, 1'b0);
          phase_next = PH_IDLE;
          cr_pending_next = 1'b0;
        end
      end
    endcase
  end

  assign push = step && emit0;

  always_comb begin
    entry.two = emit1;
    entry.first = r0;
    entry.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_ok      <= MARKER_OK_RST;
      marker_err     <= MARKER_ERR_RST;
      accept_err     <= 1'b1;
      phase          <= PH_IDLE;
      cr_pending     <= 1'b0;
      length_value   <= '0;
      length_too_big <= 1'b0;
      payload_count  <= '0;
      byte_count     <= '0;
      is_error_frame <= 1'b0;
    end else begin
      if (step) begin
        phase          <= phase_next;
        cr_pending     <= cr_pending_next;
        length_value   <= length_value_next;
        length_too_big <= length_too_big_next;
        payload_count  <= payload_count_next;
        byte_count     <= byte_count_next;
        is_error_frame <= is_error_frame_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MARKER_OK:  marker_ok <= cfg_data;
          REG_MARKER_ERR: marker_err <= cfg_data;
          REG_ACCEPT_ERR: accept_err <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/lpsfp_queue.sv
// ----------------------------------------------------------------------------
// Frame parser result queue
// Short first-in first-out buffer of result entries between front and back.
// ----------------------------------------------------------------------------
module lpsfp_queue import lpsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t status
);

  entry_t           slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign status.full  = (count == CNT_W'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: hdl/lpsfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser back end
// Splits each queue entry into its results and drives the output register.
// ----------------------------------------------------------------------------
module lpsfp_back import lpsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  q_status_t status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res,
  output logic      out_last
);

  logic sel;
  logic load;
  logic fin;
  res_t cur_res;

  assign load = !out_valid || out_ready;
  assign cur_res = sel ? head.second : head.first;
  assign fin = sel || !head.two;
  assign pop = load && !status.empty && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !status.empty;
      if (!status.empty) begin
        sel <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !status.empty) begin
      out_res  <= cur_res;
      out_last <= fin;
    end
  end

endmodule

FILE: hdl/length_prefixed_string_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Length-prefixed string frame parser core
// Parses marker, decimal length, CRLF, payload and closing CRLF one byte at
// a time, and reports payload bytes, frame completion and frame errors.
//
//   Channel  Handshake             Content
//   input    in_valid / in_ready   byte_in
//   output   out_valid / out_ready kind, payload_byte, byte_index,
//                                  declared_length, frame_bytes,
//                                  error_string, error_code, last
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken every cycle while the queue is not full; a byte that
// gives two results is held in one entry of the two-entry result queue.
// A result passes through the result queue and then the output register.
// Synchronous reset returns the parser to idle and the registers to defaults.
// An output stall fills the queue and then holds off further input.
// ----------------------------------------------------------------------------
`include "length_prefixed_string_frame_parser_core_macros.svh"

module length_prefixed_string_frame_parser_core import lpsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [7:0]           payload_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic [IDX_W-1:0]     declared_length,
  output logic [BC_W-1:0]      frame_bytes,
  output logic                 error_string,
  output logic [2:0]           error_code,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic      step;
  logic      push;
  entry_t    entry;
  entry_t    head;
  q_status_t status;
  logic      pop;
  res_t      out_res;

  assign cfg_ready = 1'b1;
  assign in_ready = !status.full;
  assign step = in_valid && in_ready;

  lpsfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .byte_in   (byte_in),
    .push      (push),
    .entry     (entry)
  );

  lpsfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  lpsfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (last)
  );

  assign kind            = out_res.kind;
  assign payload_byte    = out_res.payload_byte;
  assign byte_index      = out_res.byte_index;
  assign declared_length = out_res.declared_length;
  assign frame_bytes     = out_res.frame_bytes;
  assign error_string    = out_res.error_string;
  assign error_code      = out_res.error_code;

  `LPSFP_ASSERT_SAME(a_done_is_last, clk, rst, out_valid && kind == KIND_DONE, last,
    "completion not last")
  `LPSFP_ASSERT_SAME(a_error_is_last, clk, rst, out_valid && kind == KIND_ERROR, last,
    "error not last")
  `LPSFP_ASSERT_SAME(a_payload_clean, clk, rst, out_valid && kind == KIND_PAYLOAD,
    declared_length == '0 && frame_bytes == '0 && error_code == ERR_MARKER && !error_string,
    "payload result carries frame fields")
  `LPSFP_ASSERT_NEXT(a_no_push_full, clk, rst, status.full && !pop, !push || status.full,
    "queue overfilled")

endmodule
